/* hw/rtl/smmad_pkg.sv */
`default_nettype none

package smmad_pkg;

   // Default capacity of the age store and width of one stored age.
   localparam int MAX_ITEMS_DEF = 32;
   localparam int AGE_BITS_DEF  = 8;

   // Port field widths.
   localparam int AGE_W     = 8;
   localparam int COUNT_W   = 6;
   localparam int FX_W      = 16;
   localparam int BYTE_W    = 8;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_USER_W = 2;

   // Result tdata layout, lowest bit first.
   localparam int OFS_COUNT    = 0;
   localparam int OFS_MEAN     = OFS_COUNT + COUNT_W;
   localparam int OFS_LARGEST  = OFS_MEAN + FX_W;
   localparam int OFS_SMALLEST = OFS_LARGEST + BYTE_W;
   localparam int OFS_SPREAD   = OFS_SMALLEST + BYTE_W;
   localparam int OFS_ABS_DEV  = OFS_SPREAD + BYTE_W;
   localparam int RSP_USED_W   = OFS_ABS_DEV + FX_W;

   // Result tuser layout.
   localparam int USR_EMPTY   = 0;
   localparam int USR_DROPPED = 1;

endpackage

`default_nettype wire

/* hw/rtl/set_mean_min_max_abs_deviation_unit.sv */
// Set statistics unit.
// The request channel (req_) carries one beat per age. tdata holds the age,
// tuser[0] marks a beat that carries no age, and tlast closes the set. Ages
// are written into an on-chip store while a running sum, maximum and minimum
// follow along; an age that finds the store full is dropped and flagged.
// Loading takes one beat per cycle.
// The closing beat starts the finish sequence: a one bit per cycle divider
// forms the 8.8 mean, the store is read back one entry per cycle to sum the
// absolute deviations, and the same divider then forms the mean deviation.
// An empty set skips the divider and the walk.
// The request channel is held off only during the finish sequence.
// The result beat (rsp_) sits in an output register. While the receiver
// stalls, the next set loads normally; only the following finish waits.
// Reset is synchronous and clears the count, sum, extremes and drop flag,
// and drops any pending result. The store itself is not cleared.
`default_nettype none

module set_mean_min_max_abs_deviation_unit #(
   parameter int MAX_ITEMS = smmad_pkg::MAX_ITEMS_DEF,
   parameter int AGE_BITS  = smmad_pkg::AGE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [7:0] age
   input  wire logic [smmad_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] end_only
   input  wire logic                               req_tuser,
   input  wire logic                               req_tlast,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [5:0] count, [21:6] mean_fx, [29:22] largest, [37:30] smallest,
   // [45:38] spread, [61:46] abs_dev_fx, [63:62] zero
   output logic [smmad_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // [0] empty_res, [1] dropped
   output logic [smmad_pkg::RSP_USER_W-1:0]        rsp_tuser
);

   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W  = AGE_BITS + CNT_W;
   localparam int MEAN_W = AGE_BITS + 8;
   localparam int DIV_W  = MEAN_W + CNT_W;
   localparam int STEP_W = $clog2(DIV_W);

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MEAN  = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DEV   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   // Control and running state.
   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [AGE_BITS-1:0] max_ff, max_in;
   logic [AGE_BITS-1:0] min_ff, min_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    walk_ff, walk_in;
   logic                rd_vld_ff, rd_vld_in;

   // Datapath registers.
   logic [AGE_BITS-1:0] age_store [MAX_ITEMS];
   logic [AGE_BITS-1:0] rd_data_ff;
   logic [DIV_W-1:0]    num_ff, num_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [MEAN_W-1:0]   mean_ff, mean_in;
   logic [MEAN_W-1:0]   dev_ff, dev_in;
   logic [DIV_W-1:0]    acc_ff, acc_in;
   logic [smmad_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [smmad_pkg::RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic                req_acc;
   logic                store_age;
   logic [AGE_BITS-1:0] age_val;
   logic                issue;
   logic                out_free;
   logic [CNT_W:0]      rem_sh;
   logic                div_ge;
   logic [CNT_W:0]      rem_sub;
   logic [DIV_W-1:0]    num_nx;
   logic                div_done;
   logic [MEAN_W-1:0]   rd_fx;
   logic [MEAN_W-1:0]   abs_diff;
   logic                empty;
   logic [AGE_BITS-1:0] big, low;

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign age_val    = AGE_BITS'(req_tdata);
   assign store_age  = req_acc && !req_tuser && (cnt_ff != CNT_W'(MAX_ITEMS));
   assign issue      = (state_ff == ST_WALK) && (walk_ff != cnt_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // One restoring division step; the quotient shifts in from the bottom.
   assign rem_sh   = {rem_ff, num_ff[DIV_W-1]};
   assign div_ge   = rem_sh >= {1'b0, cnt_ff};
   assign rem_sub  = div_ge ? (rem_sh - {1'b0, cnt_ff}) : rem_sh;
   assign num_nx   = {num_ff[DIV_W-2:0], div_ge};
   assign div_done = (step_ff == '0);

   // Distance of one stored age from the fixed-point mean.
   assign rd_fx    = {rd_data_ff, 8'h00};
   assign abs_diff = (mean_ff >= rd_fx) ? (mean_ff - rd_fx) : (rd_fx - mean_ff);

   // Fields of the result; an empty set reports zeros.
   assign empty = (cnt_ff == '0);
   assign big   = empty ? '0 : max_ff;
   assign low   = empty ? '0 : min_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      walk_in      = walk_ff;
      rd_vld_in    = issue;
      num_in       = num_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      acc_in       = acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      case (state_ff)
         ST_LOAD: begin
            // Take one age per beat and keep the running figures current.
            if (req_acc && !req_tuser) begin
               if (store_age) begin
                  cnt_in = cnt_ff + 1'b1;
                  sum_in = sum_ff + SUM_W'(age_val);
                  if (age_val > max_ff) begin
                     max_in = age_val;
                  end
                  if (age_val < min_ff) begin
                     min_in = age_val;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            if (req_acc && req_tlast) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Start the mean division, or skip everything for an empty set.
            num_in  = {sum_ff, 8'h00};
            rem_in  = '0;
            step_in = STEP_W'(DIV_W - 1);
            if (empty) begin
               mean_in  = '0;
               dev_in   = '0;
               state_in = ST_FIN;
            end else begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            num_in  = num_nx;
            rem_in  = CNT_W'(rem_sub);
            step_in = step_ff - 1'b1;
            if (div_done) begin
               mean_in  = MEAN_W'(num_nx);
               walk_in  = '0;
               acc_in   = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // Read the store back and sum the absolute deviations.
            if (issue) begin
               walk_in = walk_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               acc_in = acc_ff + DIV_W'(abs_diff);
            end
            if (!issue && !rd_vld_ff) begin
               num_in   = acc_ff;
               rem_in   = '0;
               step_in  = STEP_W'(DIV_W - 1);
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            num_in  = num_nx;
            rem_in  = CNT_W'(rem_sub);
            step_in = step_ff - 1'b1;
            if (div_done) begin
               dev_in   = MEAN_W'(num_nx);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hand the result to the output register and clear the set.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               rsp_data_in[smmad_pkg::OFS_COUNT +: smmad_pkg::COUNT_W] =
                  smmad_pkg::COUNT_W'(cnt_ff);
               rsp_data_in[smmad_pkg::OFS_MEAN +: smmad_pkg::FX_W] =
                  smmad_pkg::FX_W'(mean_ff);
               rsp_data_in[smmad_pkg::OFS_LARGEST +: smmad_pkg::BYTE_W] =
                  smmad_pkg::BYTE_W'(big);
               rsp_data_in[smmad_pkg::OFS_SMALLEST +: smmad_pkg::BYTE_W] =
                  smmad_pkg::BYTE_W'(low);
               rsp_data_in[smmad_pkg::OFS_SPREAD +: smmad_pkg::BYTE_W] =
                  smmad_pkg::BYTE_W'(big - low);
               rsp_data_in[smmad_pkg::OFS_ABS_DEV +: smmad_pkg::FX_W] =
                  smmad_pkg::FX_W'(dev_ff);
               rsp_user_in[smmad_pkg::USR_EMPTY]   = empty;
               rsp_user_in[smmad_pkg::USR_DROPPED] = ovf_ff;
               cnt_in   = '0;
               sum_in   = '0;
               max_in   = '0;
               min_in   = '1;
               ovf_in   = 1'b0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
         min_ff       <= '1;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         walk_ff      <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_ff      <= walk_in;
         rd_vld_ff    <= rd_vld_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      mean_ff     <= mean_in;
      dev_ff      <= dev_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // Age store: written while loading, read back during the walk.
   always_ff @(posedge clock) begin
      if (store_age) begin
         age_store[cnt_ff[IDX_W-1:0]] <= age_val;
      end
      if (issue) begin
         rd_data_ff <= age_store[walk_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

/* hw/rtl/smmad_checker.sv */
`default_nettype none

module smmad_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   input  wire logic                               req_tready,
   input  wire logic                               req_tlast,
   input  wire logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic [smmad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic [smmad_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   logic [smmad_pkg::BYTE_W-1:0] largest, smallest, spread;
   logic                          empty;

   assign largest  = rsp_tdata[smmad_pkg::OFS_LARGEST +: smmad_pkg::BYTE_W];
   assign smallest = rsp_tdata[smmad_pkg::OFS_SMALLEST +: smmad_pkg::BYTE_W];
   assign spread   = rsp_tdata[smmad_pkg::OFS_SPREAD +: smmad_pkg::BYTE_W];
   assign empty    = rsp_tuser[smmad_pkg::USR_EMPTY];

   // A result beat that is stalled keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // Reset drops any pending result.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The closing beat puts the block into its finish sequence.
   a_busy_after_close: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken right after the closing beat");

   // An empty set reports all statistics as zero.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && empty |-> rsp_tdata[smmad_pkg::RSP_USED_W-1:0] == '0)
      else $error("empty set with nonzero statistics");

   // The spread always agrees with the two extremes.
   a_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> spread == smmad_pkg::BYTE_W'(largest - smallest))
      else $error("spread does not match largest and smallest");

endmodule

bind set_mean_min_max_abs_deviation_unit smmad_checker u_smmad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
